@@ rtl/core/sclte_pkg.sv @@
package sclte_pkg;

  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int CAP_W      = 5;
  localparam int MODE_W     = 2;
  localparam int DEV_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_MISS     = 2'd1,
    ST_DISABLED = 2'd2
  } status_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_WB     = 1'b1
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID  = 2'd2;

  localparam logic [MODE_W-1:0] WM_IMMEDIATE = 2'd0;
  localparam logic [MODE_W-1:0] WM_VIRTUAL   = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

@@ rtl/core/sector_cache_lru_tag_engine_top.sv @@
// Channel  | Direction | Handshake          | Payload
// in       | input     | in_valid/in_ready  | in_cmd, in_sector
// out      | output    | out_valid/out_ready| out_kind, out_status, out_slot, out_sector,
//          |           |                    | out_device, out_last
// cfg      | input     | cfg_we             | cfg_index, cfg_wdata
//
// One command at a time; in_ready is high only while the sequencer is idle.
// Each pass walks all CACHE_ENTRIES slots through the single tag/rank memory read port and
// one comparator. Read/write: one lookup pass, plus a rank pass on a hit. Add: lookup, one
// victim pass per eviction, one rank pass. Flush: one minimum-tag pass per valid entry, plus
// one, and no pass in virtual mode. A result word is held while out_ready is low.
// Synchronous active-low reset clears valid/dirty bits and the fill count.
module sector_cache_lru_tag_engine_top
  import sclte_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16,
  parameter int SECTOR_BITS   = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [CMD_W-1:0]              in_cmd,
  input  logic [SECTOR_BITS-1:0]        in_sector,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [STATUS_W-1:0]           out_status,
  output logic [$clog2(CACHE_ENTRIES)-1:0] out_slot,
  output logic [SECTOR_BITS-1:0]        out_sector,
  output logic [DEV_W-1:0]              out_device,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CNT_W-1:0] N_CNT = CNT_W'(CACHE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_TOUCH,
    S_WB,
    S_EVSCAN,
    S_EVICT,
    S_INS,
    S_FLSCAN,
    S_FLEMIT,
    S_DONE
  } state_t;

  logic [SECTOR_BITS-1:0] tag_mem [CACHE_ENTRIES];
  logic [IDX_W-1:0]       rank_mem [CACHE_ENTRIES];

  state_t                   state_r, state_nxt;
  logic [CAP_W-1:0]         capacity_r, capacity_nxt;
  logic [MODE_W-1:0]        write_mode_r, write_mode_nxt;
  logic [DEV_W-1:0]         device_r, device_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  logic [SECTOR_BITS-1:0]   sec_r, sec_nxt;
  logic [CACHE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CACHE_ENTRIES-1:0] dirty_r, dirty_nxt;
  logic [CACHE_ENTRIES-1:0] done_r, done_nxt;
  logic [CNT_W-1:0]         used_r, used_nxt;
  logic [CNT_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic                     p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]         p_idx_r, p_idx_nxt;
  logic                     hit_r, hit_nxt;
  logic [IDX_W-1:0]         hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]         hit_rank_r, hit_rank_nxt;
  logic                     best_vld_r, best_vld_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic [IDX_W-1:0]         best_rank_r, best_rank_nxt;
  logic [SECTOR_BITS-1:0]   best_tag_r, best_tag_nxt;
  logic                     free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  status_t                  st_status_r, st_status_nxt;
  logic [IDX_W-1:0]         st_slot_r, st_slot_nxt;
  logic [SECTOR_BITS-1:0]   st_sector_r, st_sector_nxt;
  logic                     out_valid_r, out_valid_nxt;
  kind_t                    out_kind_r, out_kind_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [IDX_W-1:0]         out_slot_r, out_slot_nxt;
  logic [SECTOR_BITS-1:0]   out_sector_r, out_sector_nxt;
  logic [DEV_W-1:0]         out_device_r, out_device_nxt;
  logic                     out_last_r, out_last_nxt;

  logic [SECTOR_BITS-1:0] tag_rd_r;
  logic [IDX_W-1:0]       rank_rd_r;
  logic [IDX_W-1:0]       rd_addr;
  logic                   tag_we;
  logic                   rank_we;
  logic [IDX_W-1:0]       rank_waddr;
  logic [IDX_W-1:0]       rank_wdata;

  logic             scanning;
  logic             scan_full;
  logic             scan_end;
  logic             e_valid;
  logic             out_free;
  logic             need_evict;
  logic             more_evict;
  logic [CNT_W-1:0] used_dec;
  logic             ev_emit;

  assign scanning = (state_r == S_FIND) || (state_r == S_TOUCH) || (state_r == S_EVSCAN) ||
                    (state_r == S_INS) || (state_r == S_FLSCAN);
  assign scan_full  = (scan_idx_r == N_CNT);
  assign scan_end   = scan_full && !p_vld_r;
  assign rd_addr    = scan_full ? '0 : scan_idx_r[IDX_W-1:0];
  assign e_valid    = valid_r[p_idx_r];
  assign out_free   = !out_valid_r || out_ready;
  assign used_dec   = used_r - CNT_W'(1);
  assign need_evict = (CMP_W'(used_r) >= CMP_W'(capacity_r)) || (used_r == N_CNT);
  assign more_evict = (CMP_W'(used_dec) >= CMP_W'(capacity_r));
  assign ev_emit    = best_vld_r && dirty_r[best_idx_r] && (write_mode_r != WM_VIRTUAL);

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_sector = out_sector_r;
  assign out_device = out_device_r;
  assign out_last   = out_last_r;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[free_idx_r] <= sec_r;
    end
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    tag_rd_r  <= tag_mem[rd_addr];
    rank_rd_r <= rank_mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    capacity_nxt   = capacity_r;
    write_mode_nxt = write_mode_r;
    device_nxt     = device_r;
    cmd_nxt        = cmd_r;
    sec_nxt        = sec_r;
    valid_nxt      = valid_r;
    dirty_nxt      = dirty_r;
    done_nxt       = done_r;
    used_nxt       = used_r;
    scan_idx_nxt   = (scanning && !scan_full) ? scan_idx_r + CNT_W'(1) : scan_idx_r;
    p_vld_nxt      = scanning && !scan_full;
    p_idx_nxt      = rd_addr;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_rank_nxt   = hit_rank_r;
    best_vld_nxt   = best_vld_r;
    best_idx_nxt   = best_idx_r;
    best_rank_nxt  = best_rank_r;
    best_tag_nxt   = best_tag_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    st_status_nxt  = st_status_r;
    st_slot_nxt    = st_slot_r;
    st_sector_nxt  = st_sector_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_sector_nxt = out_sector_r;
    out_device_nxt = out_device_r;
    out_last_nxt   = out_last_r;
    tag_we         = 1'b0;
    rank_we        = 1'b0;
    rank_waddr     = p_idx_r;
    rank_wdata     = rank_rd_r + IDX_W'(1);

    if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY:   capacity_nxt   = cfg_wdata[CAP_W-1:0];
        CFG_WRITE_MODE: write_mode_nxt = cfg_wdata[MODE_W-1:0];
        CFG_DEVICE_ID:  device_nxt     = cfg_wdata[DEV_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = cmd_t'(in_cmd);
          sec_nxt      = in_sector;
          scan_idx_nxt = '0;
          hit_nxt      = 1'b0;
          if (capacity_r == '0) begin
            st_status_nxt = ST_DISABLED;
            st_slot_nxt   = '0;
            st_sector_nxt = (cmd_t'(in_cmd) == CMD_FLUSH) ? '0 : in_sector;
            state_nxt     = S_DONE;
          end else if (cmd_t'(in_cmd) == CMD_FLUSH) begin
            st_status_nxt = ST_OK;
            st_slot_nxt   = '0;
            st_sector_nxt = '0;
            done_nxt      = '0;
            best_vld_nxt  = 1'b0;
            state_nxt     = (write_mode_r == WM_VIRTUAL) ? S_DONE : S_FLSCAN;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end

      S_FIND: begin
        if (p_vld_r && e_valid && (tag_rd_r == sec_r) && !hit_r) begin
          hit_nxt      = 1'b1;
          hit_idx_nxt  = p_idx_r;
          hit_rank_nxt = rank_rd_r;
        end
        if (scan_end) begin
          scan_idx_nxt  = '0;
          st_sector_nxt = sec_r;
          st_slot_nxt   = hit_r ? hit_idx_r : '0;
          st_status_nxt = ST_OK;
          if (!hit_r) begin
            if (cmd_r == CMD_ADD) begin
              best_vld_nxt = 1'b0;
              free_vld_nxt = 1'b0;
              state_nxt    = need_evict ? S_EVSCAN : S_INS;
            end else begin
              st_status_nxt = ST_MISS;
              state_nxt     = S_DONE;
            end
          end else if (cmd_r == CMD_ADD) begin
            st_status_nxt = ST_MISS;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = S_TOUCH;
          end
        end
      end

      S_TOUCH: begin
        if (p_vld_r && e_valid) begin
          if (p_idx_r == hit_idx_r) begin
            rank_we    = 1'b1;
            rank_wdata = '0;
          end else if (rank_rd_r < hit_rank_r) begin
            rank_we = 1'b1;
          end
        end
        if (scan_end) begin
          if (cmd_r == CMD_WRITE) begin
            if (write_mode_r == WM_IMMEDIATE) begin
              dirty_nxt[hit_idx_r] = 1'b0;
              state_nxt            = S_WB;
            end else begin
              dirty_nxt[hit_idx_r] = 1'b1;
              state_nxt            = S_DONE;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_WB: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_WB;
          out_status_nxt = ST_OK;
          out_slot_nxt   = hit_idx_r;
          out_sector_nxt = sec_r;
          out_device_nxt = device_r;
          out_last_nxt   = 1'b0;
          state_nxt      = S_DONE;
        end
      end

      S_EVSCAN: begin
        if (p_vld_r && e_valid && (!best_vld_r || (rank_rd_r > best_rank_r))) begin
          best_vld_nxt  = 1'b1;
          best_idx_nxt  = p_idx_r;
          best_rank_nxt = rank_rd_r;
          best_tag_nxt  = tag_rd_r;
        end
        if (scan_end) begin
          state_nxt = S_EVICT;
        end
      end

      S_EVICT: begin
        if (!best_vld_r) begin
          used_nxt     = '0;
          scan_idx_nxt = '0;
          state_nxt    = S_INS;
        end else if (!ev_emit || out_free) begin
          if (ev_emit) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_WB;
            out_status_nxt = ST_OK;
            out_slot_nxt   = best_idx_r;
            out_sector_nxt = best_tag_r;
            out_device_nxt = device_r;
            out_last_nxt   = 1'b0;
          end
          valid_nxt[best_idx_r] = 1'b0;
          dirty_nxt[best_idx_r] = 1'b0;
          used_nxt              = used_dec;
          best_vld_nxt          = 1'b0;
          scan_idx_nxt          = '0;
          state_nxt             = more_evict ? S_EVSCAN : S_INS;
        end
      end

      S_INS: begin
        if (p_vld_r) begin
          if (e_valid) begin
            rank_we = 1'b1;
          end else if (!free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = p_idx_r;
          end
        end
        if (scan_end) begin
          if (free_vld_r) begin
            tag_we                = 1'b1;
            rank_we               = 1'b1;
            rank_waddr            = free_idx_r;
            rank_wdata            = '0;
            valid_nxt[free_idx_r] = 1'b1;
            dirty_nxt[free_idx_r] = 1'b0;
            used_nxt              = used_r + CNT_W'(1);
            st_status_nxt         = ST_OK;
            st_slot_nxt           = free_idx_r;
          end else begin
            st_status_nxt = ST_DISABLED;
            st_slot_nxt   = '0;
          end
          state_nxt = S_DONE;
        end
      end

      S_FLSCAN: begin
        if (p_vld_r && e_valid && !done_r[p_idx_r] &&
            (!best_vld_r || (tag_rd_r < best_tag_r))) begin
          best_vld_nxt = 1'b1;
          best_idx_nxt = p_idx_r;
          best_tag_nxt = tag_rd_r;
        end
        if (scan_end) begin
          state_nxt = best_vld_r ? S_FLEMIT : S_DONE;
        end
      end

      S_FLEMIT: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_kind_nxt          = KIND_WB;
          out_status_nxt        = ST_OK;
          out_slot_nxt          = best_idx_r;
          out_sector_nxt        = best_tag_r;
          out_device_nxt        = device_r;
          out_last_nxt          = 1'b0;
          done_nxt[best_idx_r]  = 1'b1;
          dirty_nxt[best_idx_r] = 1'b0;
          best_vld_nxt          = 1'b0;
          scan_idx_nxt          = '0;
          state_nxt             = S_FLSCAN;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_STATUS;
          out_status_nxt = st_status_r;
          out_slot_nxt   = st_slot_r;
          out_sector_nxt = st_sector_r;
          out_device_nxt = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      capacity_r   <= CAP_RESET;
      write_mode_r <= WM_IMMEDIATE;
      device_r     <= '0;
      valid_r      <= '0;
      dirty_r      <= '0;
      done_r       <= '0;
      used_r       <= '0;
      scan_idx_r   <= '0;
      p_vld_r      <= 1'b0;
      hit_r        <= 1'b0;
      best_vld_r   <= 1'b0;
      free_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      capacity_r   <= capacity_nxt;
      write_mode_r <= write_mode_nxt;
      device_r     <= device_nxt;
      valid_r      <= valid_nxt;
      dirty_r      <= dirty_nxt;
      done_r       <= done_nxt;
      used_r       <= used_nxt;
      scan_idx_r   <= scan_idx_nxt;
      p_vld_r      <= p_vld_nxt;
      hit_r        <= hit_nxt;
      best_vld_r   <= best_vld_nxt;
      free_vld_r   <= free_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    sec_r        <= sec_nxt;
    p_idx_r      <= p_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_rank_r   <= hit_rank_nxt;
    best_idx_r   <= best_idx_nxt;
    best_rank_r  <= best_rank_nxt;
    best_tag_r   <= best_tag_nxt;
    free_idx_r   <= free_idx_nxt;
    st_status_r  <= st_status_nxt;
    st_slot_r    <= st_slot_nxt;
    st_sector_r  <= st_sector_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_sector_r <= out_sector_nxt;
    out_device_r <= out_device_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    used_r == CNT_W'($countones(valid_r)))
    else $error("fill count differs from number of valid entries");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after a command was taken");

  a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT) |-> best_vld_r)
    else $error("eviction without a valid victim");

  a_no_wb_virtual: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && (out_kind_r == KIND_WB)) |-> ($past(write_mode_r) != WM_VIRTUAL))
    else $error("write-back word issued in virtual mode");

endmodule
